// File: hw/rtl/masked_bilinear_ratio_lookup_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the masked bilinear ratio lookup
// Clocked property wrappers shared by the checker.
// ---------------------------------------------------------------------------
`ifndef MASKED_BILINEAR_RATIO_LOOKUP_TOP_ASSERT_SVH
`define MASKED_BILINEAR_RATIO_LOOKUP_TOP_ASSERT_SVH

// property checked outside reset
`define MBRL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mbrl assertion failed");

// property that must also hold across reset
`define MBRL_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mbrl reset assertion failed");

`endif

// File: hw/rtl/mbrl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbrl_pkg
// Shared constants, codes and controller/datapath types.
// ---------------------------------------------------------------------------
package mbrl_pkg;

  localparam int TBL_DIM = 128;
  localparam int AX_AW   = $clog2(TBL_DIM);
  localparam int TBL_AW  = 2 * AX_AW;
  localparam int TBL_DEP = TBL_DIM * TBL_DIM;
  localparam int CNT_W   = 8;
  localparam int DAT_W   = 32;
  localparam int Q_FRAC  = 16;
  localparam int FR_W    = Q_FRAC + 1;
  localparam int W_W     = 2 * Q_FRAC + 1;

  // divider sizes: signed operands, magnitudes, bits per cycle
  localparam int DIV_NW  = 66;
  localparam int DIV_DW  = 34;
  localparam int DIV_MW  = 64;
  localparam int DIV_DMW = 33;
  localparam int DIV_SPC = 2;
  localparam int DIV_CYC = DIV_MW / DIV_SPC;
  localparam int DIV_CW  = $clog2(DIV_CYC);

  localparam logic [FR_W-1:0]         ONE_Q16  = 17'h1_0000;
  localparam logic signed [DAT_W-1:0] MISS_LIM = 32'shFFFF_0000;

  typedef enum logic [2:0] {
    OP_LOAD_X   = 3'd0,
    OP_LOAD_Y   = 3'd1,
    OP_LOAD_IDX = 3'd2,
    OP_LOAD_CHL = 3'd3,
    OP_COMP     = 3'd4
  } op_code_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CHL  = 2'd1,
    ST_REFL = 2'd2,
    ST_MISS = 2'd3
  } stat_e;

  typedef enum logic {
    CFG_X_CNT = 1'b0,
    CFG_Y_CNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_STAT,
    CMD_RDIV,
    CMD_RLATCH,
    CMD_CMIN,
    CMD_CMAX,
    CMD_SRCH,
    CMD_RLO,
    CMD_RHI,
    CMD_FDIV,
    CMD_FDONE,
    CMD_FZERO,
    CMD_CRD,
    CMD_CMUL,
    CMD_CACC,
    CMD_IDIV,
    CMD_ILATCH,
    CMD_CLATCH,
    CMD_OUT
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_RDIV, S_CMIN, S_CMAX, S_SRCH, S_RLO, S_RHI,
    S_FSTART, S_FDIV, S_NEXT, S_CRD, S_CMUL, S_CACC, S_WCHK,
    S_IDIV, S_CDIV, S_FIN
  } ctl_st_e;

  typedef struct packed {
    dp_op_e     op;
    logic       ax;
    logic [1:0] corner;
    stat_e      stat;
  } dp_cmd_t;

  typedef struct packed {
    logic op_comp;
    logic chl_bad;
    logic refl_bad;
    logic div_done;
    logic cnt_min;
    logic srch_end;
    logic den_zero;
    logic wt_zero;
    logic out_free;
  } dp_sts_t;

  // axis count as used: below 2 acts as 2, above the table size as the size
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c < CNT_W'(2)) r = CNT_W'(2);
    else if (c > CNT_W'(TBL_DIM)) r = CNT_W'(TBL_DIM);
    else r = c;
    return r;
  endfunction

endpackage

// File: hw/rtl/masked_bilinear_ratio_lookup_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// masked_bilinear_ratio_lookup_top
// Band-ratio lookup with masked bilinear interpolation of two 2-D tables.
// ---------------------------------------------------------------------------
//  channel | handshake          | beat contents
//  --------+--------------------+-----------------------------------------
//  in_     | in_valid/in_stall  | operation, selects, load value, pixel
//  out_    | out_valid/out_stall| index, chlorophyll, status
//  cfg_    | cfg_valid/cfg_ready| register index, 8-bit axis count
//
// Loads and unused codes complete when accepted. A compute beat skips the
// divider on a bad chlorophyll or reflectance and otherwise makes up to six
// passes through the shared 2-bit-per-cycle divider plus a bracket search
// of one axis entry per cycle on each axis.
// Reset is synchronous; the tables and axes hold no reset value.
// in_stall is high while a compute beat is in progress; a waiting result
// does not block the next beat, only its own completion.
// ---------------------------------------------------------------------------
module masked_bilinear_ratio_lookup_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic [6:0]         in_column_select,
  input  logic [6:0]         in_row_select,
  input  logic signed [31:0] in_load_value,
  input  logic signed [31:0] in_chlorophyll_in,
  input  logic signed [31:0] in_refl_412,
  input  logic signed [31:0] in_refl_443,
  input  logic signed [31:0] in_refl_490,
  input  logic signed [31:0] in_refl_555,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_index_out,
  output logic signed [31:0] out_chlorophyll_out,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data
);
  import mbrl_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // configuration writes are always accepted
  assign cfg_ready = 1'b1;

  mbrl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  mbrl_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_operation(in_operation), .in_column_select(in_column_select),
    .in_row_select(in_row_select), .in_load_value(in_load_value),
    .in_chlorophyll_in(in_chlorophyll_in), .in_refl_412(in_refl_412),
    .in_refl_443(in_refl_443), .in_refl_490(in_refl_490),
    .in_refl_555(in_refl_555),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_index_out(out_index_out), .out_chlorophyll_out(out_chlorophyll_out),
    .out_status(out_status)
  );

endmodule

// File: hw/rtl/mbrl_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbrl_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module mbrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/mbrl_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbrl_div
// Signed restoring divider, two quotient bits per cycle, truncates to zero.
// ---------------------------------------------------------------------------
module mbrl_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [mbrl_pkg::DIV_NW-1:0] num,
  input  logic signed [mbrl_pkg::DIV_DW-1:0] den,
  output logic                             done,
  output logic signed [mbrl_pkg::DIV_NW-1:0] quot
);
  import mbrl_pkg::*;

  logic                     busy_r;
  logic                     done_r;
  logic [DIV_CW-1:0]        step_r;
  logic [DIV_MW-1:0]        nq_r;
  logic [DIV_DMW-1:0]       rem_r;
  logic [DIV_DMW-1:0]       d_r;
  logic                     neg_r;
  logic signed [DIV_NW-1:0] num_mag;
  logic signed [DIV_DW-1:0] den_mag;
  logic [DIV_MW-1:0]        nq_nxt;
  logic [DIV_DMW-1:0]       rem_nxt;
  logic signed [DIV_NW-1:0] q_mag;

  assign num_mag = num[DIV_NW-1] ? -num : num;
  assign den_mag = den[DIV_DW-1] ? -den : den;

  // two restoring steps per cycle
  always_comb begin
    logic [DIV_DMW:0] sh;
    nq_nxt  = nq_r;
    rem_nxt = rem_r;
    for (int s = 0; s < DIV_SPC; s++) begin
      sh = {rem_nxt, nq_nxt[DIV_MW-1]};
      if (sh >= {1'b0, d_r}) begin
        rem_nxt = DIV_DMW'(sh - {1'b0, d_r});
        nq_nxt  = {nq_nxt[DIV_MW-2:0], 1'b1};
      end else begin
        rem_nxt = sh[DIV_DMW-1:0];
        nq_nxt  = {nq_nxt[DIV_MW-2:0], 1'b0};
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + DIV_CW'(1);
        if (step_r == DIV_CW'(DIV_CYC - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      nq_r  <= num_mag[DIV_MW-1:0];
      d_r   <= den_mag[DIV_DMW-1:0];
      rem_r <= '0;
      neg_r <= num[DIV_NW-1] ^ den[DIV_DW-1];
    end else if (busy_r) begin
      nq_r  <= nq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign q_mag = $signed(DIV_NW'(nq_r));
  assign quot  = neg_r ? -q_mag : q_mag;
  assign done  = done_r;

endmodule

// File: hw/rtl/mbrl_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbrl_ctrl
// Sequencer: ratios, clamp, bracket search, fractions, corners, divisions.
// ---------------------------------------------------------------------------
module mbrl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mbrl_pkg::dp_sts_t sts,
  output mbrl_pkg::dp_cmd_t cmd
);
  import mbrl_pkg::*;

  ctl_st_e    state_r, state_nxt;
  logic       ax_r, ax_nxt;
  logic [1:0] corner_r, corner_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ax_r     <= 1'b0;
      corner_r <= '0;
    end else begin
      state_r  <= state_nxt;
      ax_r     <= ax_nxt;
      corner_r <= corner_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ax_nxt     = ax_r;
    corner_nxt = corner_r;
    cmd.op     = CMD_NONE;
    cmd.ax     = ax_r;
    cmd.corner = corner_r;
    cmd.stat   = ST_OK;
    in_stall   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = CMD_CAPTURE;
          if (sts.op_comp) state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.chl_bad) begin
          cmd.op    = CMD_STAT;
          cmd.stat  = ST_CHL;
          state_nxt = S_FIN;
        end else if (sts.refl_bad) begin
          cmd.op    = CMD_STAT;
          cmd.stat  = ST_REFL;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = CMD_RDIV;
          cmd.ax    = 1'b0;
          ax_nxt    = 1'b0;
          state_nxt = S_RDIV;
        end
      end
      S_RDIV: begin
        if (sts.div_done) begin
          cmd.op    = CMD_RLATCH;
          state_nxt = S_CMIN;
        end
      end
      S_CMIN: begin
        cmd.op    = CMD_CMIN;
        state_nxt = S_CMAX;
      end
      S_CMAX: begin
        cmd.op    = CMD_CMAX;
        state_nxt = sts.cnt_min ? S_RLO : S_SRCH;
      end
      S_SRCH: begin
        cmd.op = CMD_SRCH;
        if (sts.srch_end) state_nxt = S_RLO;
      end
      S_RLO: begin
        cmd.op    = CMD_RLO;
        state_nxt = S_RHI;
      end
      S_RHI: begin
        cmd.op    = CMD_RHI;
        state_nxt = S_FSTART;
      end
      S_FSTART: begin
        if (sts.den_zero) begin
          cmd.op    = CMD_FZERO;
          state_nxt = S_NEXT;
        end else begin
          cmd.op    = CMD_FDIV;
          state_nxt = S_FDIV;
        end
      end
      S_FDIV: begin
        if (sts.div_done) begin
          cmd.op    = CMD_FDONE;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (!ax_r) begin
          cmd.op    = CMD_RDIV;
          cmd.ax    = 1'b1;
          ax_nxt    = 1'b1;
          state_nxt = S_RDIV;
        end else begin
          corner_nxt = '0;
          state_nxt  = S_CRD;
        end
      end
      S_CRD: begin
        cmd.op    = CMD_CRD;
        state_nxt = S_CMUL;
      end
      S_CMUL: begin
        cmd.op    = CMD_CMUL;
        state_nxt = S_CACC;
      end
      S_CACC: begin
        cmd.op     = CMD_CACC;
        corner_nxt = corner_r + 2'd1;
        state_nxt  = (corner_r == 2'd3) ? S_WCHK : S_CRD;
      end
      S_WCHK: begin
        if (sts.wt_zero) begin
          cmd.op    = CMD_STAT;
          cmd.stat  = ST_MISS;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = CMD_IDIV;
          state_nxt = S_IDIV;
        end
      end
      S_IDIV: begin
        if (sts.div_done) begin
          cmd.op    = CMD_ILATCH;
          state_nxt = S_CDIV;
        end
      end
      S_CDIV: begin
        if (sts.div_done) begin
          cmd.op    = CMD_CLATCH;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.op    = CMD_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/mbrl_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbrl_dp
// Datapath: axis and table memories, shared divider, weights, output beat.
// ---------------------------------------------------------------------------
module mbrl_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [2:0]                        in_operation,
  input  logic [6:0]                        in_column_select,
  input  logic [6:0]                        in_row_select,
  input  logic signed [31:0]                in_load_value,
  input  logic signed [31:0]                in_chlorophyll_in,
  input  logic signed [31:0]                in_refl_412,
  input  logic signed [31:0]                in_refl_443,
  input  logic signed [31:0]                in_refl_490,
  input  logic signed [31:0]                in_refl_555,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [7:0]                        cfg_data,
  input  mbrl_pkg::dp_cmd_t                 cmd,
  output mbrl_pkg::dp_sts_t                 sts,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [31:0]                out_index_out,
  output logic signed [31:0]                out_chlorophyll_out,
  output logic [1:0]                        out_status
);
  import mbrl_pkg::*;

  // configuration
  logic [CNT_W-1:0] xcnt_r, ycnt_r, cnt;

  // captured item
  logic signed [DAT_W-1:0] chl_r, r412_r, r443_r, r490_r, r555_r;

  // per-axis working state
  logic signed [DIV_NW-1:0] r_r;
  logic [AX_AW-1:0]         kq_r, k_r, k_hit;
  logic signed [DAT_W-1:0]  lo_r, hi_r;
  logic [AX_AW-1:0]         i_r, j_r;
  logic [FR_W-1:0]          t_r, u_r, frac;

  // corner accumulation
  logic [W_W-1:0]           w_r, wm;
  logic [2*FR_W-1:0]        wprod;
  logic [FR_W-1:0]          fa, fb;
  logic [DIV_DW-1:0]        wt_r;
  logic signed [DIV_DW-1:0] wms;
  logic signed [DIV_NW-1:0] pi_r, pc_r, acc_i_r, acc_c_r;
  logic                     miss;

  // results
  logic signed [DAT_W-1:0]  idx_r, chlo_r;
  stat_e                    st_r;
  logic                     out_valid_r;
  logic signed [DAT_W-1:0]  out_idx_r, out_chl_r;
  stat_e                    out_st_r;

  // memories
  logic                     xr_we, yr_we, it_we, ct_we;
  logic [AX_AW-1:0]         ax_raddr, col, row;
  logic [TBL_AW-1:0]        tab_waddr, tab_raddr;
  logic [DAT_W-1:0]         xr_rdata, yr_rdata, it_rdata, ct_rdata;
  logic signed [DAT_W-1:0]  ax_data, idata, cdata;

  // divider
  logic                     div_start, div_done;
  logic signed [DIV_NW-1:0] div_num, div_q;
  logic signed [DIV_DW-1:0] div_den;
  logic signed [DAT_W-1:0]  sel_num, sel_den;

  logic                     hit, last;

  mbrl_ram #(.WIDTH(DAT_W), .DEPTH(TBL_DIM)) u_xaxis (
    .clk(clk), .we(xr_we), .waddr(in_column_select), .wdata(in_load_value),
    .raddr(ax_raddr), .rdata(xr_rdata)
  );
  mbrl_ram #(.WIDTH(DAT_W), .DEPTH(TBL_DIM)) u_yaxis (
    .clk(clk), .we(yr_we), .waddr(in_row_select), .wdata(in_load_value),
    .raddr(ax_raddr), .rdata(yr_rdata)
  );
  mbrl_ram #(.WIDTH(DAT_W), .DEPTH(TBL_DEP)) u_itab (
    .clk(clk), .we(it_we), .waddr(tab_waddr), .wdata(in_load_value),
    .raddr(tab_raddr), .rdata(it_rdata)
  );
  mbrl_ram #(.WIDTH(DAT_W), .DEPTH(TBL_DEP)) u_ctab (
    .clk(clk), .we(ct_we), .waddr(tab_waddr), .wdata(in_load_value),
    .raddr(tab_raddr), .rdata(ct_rdata)
  );

  mbrl_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_q)
  );

  assign cnt     = eff_count(cmd.ax ? ycnt_r : xcnt_r);
  assign ax_data = $signed(cmd.ax ? yr_rdata : xr_rdata);
  assign idata   = $signed(it_rdata);
  assign cdata   = $signed(ct_rdata);

  assign tab_waddr = TBL_AW'(in_column_select) * TBL_AW'(TBL_DIM) + TBL_AW'(in_row_select);

  // corner address and weight factors
  assign col       = cmd.corner[1] ? i_r + AX_AW'(1) : i_r;
  assign row       = (cmd.corner[0] ^ cmd.corner[1]) ? j_r + AX_AW'(1) : j_r;
  assign tab_raddr = TBL_AW'(col) * TBL_AW'(TBL_DIM) + TBL_AW'(row);
  assign fa        = cmd.corner[1] ? t_r : ONE_Q16 - t_r;
  assign fb        = (cmd.corner[0] ^ cmd.corner[1]) ? u_r : ONE_Q16 - u_r;
  assign wprod     = (2*FR_W)'(fa) * (2*FR_W)'(fb);

  // missing corner masks its weight
  assign miss = (idata <= MISS_LIM);
  assign wm   = miss ? '0 : w_r;
  assign wms  = $signed({{(DIV_DW-W_W){1'b0}}, wm});

  // bracket search step
  assign hit   = (DIV_NW'(ax_data) > r_r);
  assign last  = (CNT_W'(kq_r) == cnt - CNT_W'(3));
  assign k_hit = hit ? kq_r : AX_AW'(cnt - CNT_W'(2));

  // fraction saturated to [0, 1]
  always_comb begin
    if (div_q[DIV_NW-1]) frac = '0;
    else if (div_q > DIV_NW'(ONE_Q16)) frac = ONE_Q16;
    else frac = div_q[FR_W-1:0];
  end

  assign sel_num = cmd.ax ? r490_r : r412_r;
  assign sel_den = cmd.ax ? r555_r : r443_r;

  // memory, divider and address control
  always_comb begin
    xr_we     = 1'b0;
    yr_we     = 1'b0;
    it_we     = 1'b0;
    ct_we     = 1'b0;
    ax_raddr  = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (cmd.op)
      CMD_CAPTURE: begin
        xr_we = (in_operation == OP_LOAD_X);
        yr_we = (in_operation == OP_LOAD_Y);
        it_we = (in_operation == OP_LOAD_IDX);
        ct_we = (in_operation == OP_LOAD_CHL);
      end
      CMD_RDIV: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(sel_num) <<< Q_FRAC;
        div_den   = DIV_DW'(sel_den);
      end
      CMD_RLATCH: ax_raddr = AX_AW'(cnt - CNT_W'(1));
      CMD_CMIN:   ax_raddr = '0;
      CMD_CMAX:   ax_raddr = (cnt == CNT_W'(2)) ? '0 : AX_AW'(1);
      CMD_SRCH:   ax_raddr = (hit || last) ? k_hit : kq_r + AX_AW'(2);
      CMD_RLO:    ax_raddr = k_r + AX_AW'(1);
      CMD_FDIV: begin
        div_start = 1'b1;
        div_num   = (r_r - DIV_NW'(lo_r)) <<< Q_FRAC;
        div_den   = DIV_DW'(hi_r) - DIV_DW'(lo_r);
      end
      CMD_IDIV: begin
        div_start = 1'b1;
        div_num   = acc_i_r;
        div_den   = $signed(wt_r);
      end
      CMD_ILATCH: begin
        div_start = 1'b1;
        div_num   = acc_c_r;
        div_den   = $signed(wt_r);
      end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xcnt_r <= CNT_W'(2);
      ycnt_r <= CNT_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_CNT: xcnt_r <= cfg_data;
        CFG_Y_CNT: ycnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_CAPTURE: begin
        chl_r   <= in_chlorophyll_in;
        r412_r  <= in_refl_412;
        r443_r  <= in_refl_443;
        r490_r  <= in_refl_490;
        r555_r  <= in_refl_555;
        st_r    <= ST_OK;
        idx_r   <= '0;
        chlo_r  <= '0;
        wt_r    <= '0;
        acc_i_r <= '0;
        acc_c_r <= '0;
      end
      CMD_STAT:   st_r <= cmd.stat;
      CMD_RLATCH: r_r <= div_q;
      CMD_CMIN:   if (r_r > DIV_NW'(ax_data)) r_r <= DIV_NW'(ax_data);
      CMD_CMAX: begin
        if (r_r < DIV_NW'(ax_data)) r_r <= DIV_NW'(ax_data);
        kq_r <= '0;
        k_r  <= '0;
      end
      CMD_SRCH: begin
        if (hit || last) k_r <= k_hit;
        else kq_r <= kq_r + AX_AW'(1);
      end
      CMD_RLO: lo_r <= ax_data;
      CMD_RHI: hi_r <= ax_data;
      CMD_FDONE: begin
        if (cmd.ax) begin
          u_r <= frac;
          j_r <= k_r;
        end else begin
          t_r <= frac;
          i_r <= k_r;
        end
      end
      CMD_FZERO: begin
        if (cmd.ax) begin
          u_r <= '0;
          j_r <= k_r;
        end else begin
          t_r <= '0;
          i_r <= k_r;
        end
      end
      CMD_CRD: w_r <= wprod[W_W-1:0];
      CMD_CMUL: begin
        wt_r <= wt_r + DIV_DW'(wm);
        pi_r <= idata * wms;
        pc_r <= cdata * wms;
      end
      CMD_CACC: begin
        acc_i_r <= acc_i_r + pi_r;
        acc_c_r <= acc_c_r + pc_r;
      end
      CMD_ILATCH: idx_r  <= div_q[DAT_W-1:0];
      CMD_CLATCH: chlo_r <= div_q[DAT_W-1:0];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == CMD_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_OUT) begin
      out_idx_r <= idx_r;
      out_chl_r <= chlo_r;
      out_st_r  <= st_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_index_out       = out_idx_r;
  assign out_chlorophyll_out = out_chl_r;
  assign out_status          = out_st_r;

  // status to the sequencer
  assign sts.op_comp  = (in_operation == OP_COMP);
  assign sts.chl_bad  = chl_r[DAT_W-1] || (chl_r == '0);
  assign sts.refl_bad = r443_r[DAT_W-1] || (r443_r == '0) ||
                        r555_r[DAT_W-1] || (r555_r == '0);
  assign sts.div_done = div_done;
  assign sts.cnt_min  = (cnt == CNT_W'(2));
  assign sts.srch_end = hit || last;
  assign sts.den_zero = (hi_r == lo_r);
  assign sts.wt_zero  = (wt_r == '0);
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

// File: hw/rtl/mbrl_chk.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mbrl_chk
// Port-level checker for the ratio lookup, bound to the top level.
// ---------------------------------------------------------------------------
`include "masked_bilinear_ratio_lookup_top_assert.svh"

module mbrl_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [2:0]         in_operation,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_index_out,
  input logic signed [31:0] out_chlorophyll_out,
  input logic [1:0]         out_status
);
  import mbrl_pkg::*;

  logic [65:0] out_beat;

  // whole result beat as one vector
  assign out_beat = {out_index_out, out_chlorophyll_out, out_status};

  // a held result beat keeps its payload
  `MBRL_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_beat))

  // no result beat straight out of reset
  `MBRL_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_valid)

  // any error status carries zero values
  `MBRL_ASSERT(a_err_zero, out_valid && out_status != ST_OK |-> out_beat[65:2] == '0)

  // a compute beat occupies the block for at least the next cycle
  `MBRL_ASSERT(a_comp_busy, in_valid && !in_stall && in_operation == OP_COMP |=> in_stall)

endmodule

bind masked_bilinear_ratio_lookup_top mbrl_chk u_mbrl_chk (.*);

// File: test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Masked bilinear ratio lookup testbench
// Loads both axes and the corner of both tables that computes can reach, then
// runs a directed table followed by random loads and computes over several
// axis count settings. Axis entries past the reachable corner sit far above
// any ratio sent, so every bracket stays inside the loaded corner. Every
// compute beat is predicted in the testbench and compared field by field with
// the result beats. Input and result sides idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;
  import mbrl_pkg::*;

  localparam int DIM = 128;
  localparam int REG = 9; // table rows and columns a bracket can touch
  localparam logic signed [31:0] MISSING = -32'sd65470464; // -999.0 in Q16.16
  localparam int PHASE_BEATS = 201;
  localparam int SETTLE = 600;

  typedef struct packed {
    logic [2:0]         op;
    logic [6:0]         col;
    logic [6:0]         row;
    logic signed [31:0] val;
    logic signed [31:0] chl;
    logic signed [31:0] r412;
    logic signed [31:0] r443;
    logic signed [31:0] r490;
    logic signed [31:0] r555;
  } pixel_beat_t;

  typedef struct packed {
    logic signed [31:0] idx;
    logic signed [31:0] chl;
    logic [1:0]         st;
  } lookup_res_t;

  typedef struct packed {
    pixel_beat_t b;
    logic        typed;
    lookup_res_t r;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_operation = '0;
  logic [6:0] in_column_select = '0;
  logic [6:0] in_row_select = '0;
  logic signed [31:0] in_load_value = '0;
  logic signed [31:0] in_chlorophyll_in = '0;
  logic signed [31:0] in_refl_412 = '0;
  logic signed [31:0] in_refl_443 = '0;
  logic signed [31:0] in_refl_490 = '0;
  logic signed [31:0] in_refl_555 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_index_out;
  logic signed [31:0] out_chlorophyll_out;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [7:0] cfg_data = '0;

  masked_bilinear_ratio_lookup_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the block state
  int x_ax [DIM];
  int y_ax [DIM];
  int idx_tbl [DIM*DIM];
  int chl_tbl [DIM*DIM];
  int x_cnt = 2;
  int y_cnt = 2;

  lookup_res_t pending_lookups[$];
  int errors = 0;
  int burst_left = 0;

  // axis entry as the block sees it
  function automatic longint axis_at(input bit on_y, input int k);
    return on_y ? longint'(y_ax[k]) : longint'(x_ax[k]);
  endfunction

  // clamp to axis, find bracketing interval, return Q16 fraction
  function automatic longint bracket_frac(input bit on_y, input int cnt, input longint ratio,
                                          output int bracket);
    int n;
    int k;
    longint den;
    longint t;
    n = (cnt < 2) ? 2 : (cnt > DIM ? DIM : cnt);
    if (ratio > axis_at(on_y, n-1)) ratio = axis_at(on_y, n-1);
    if (ratio < axis_at(on_y, 0)) ratio = axis_at(on_y, 0);
    for (k = 0; k < n - 2; k++)
      if (axis_at(on_y, k+1) > ratio) break;
    bracket = k;
    den = axis_at(on_y, k+1) - axis_at(on_y, k);
    if (den == 0) return 0;
    t = ((ratio - axis_at(on_y, k)) * 65536) / den;
    if (t < 0) t = 0;
    if (t > 65536) t = 65536;
    return t;
  endfunction

  // masked bilinear lookup of one pixel
  function automatic lookup_res_t lookup_pixel(input pixel_beat_t b);
    lookup_res_t r;
    longint t, u, wt, num_i, num_c;
    longint w [4];
    int a [4];
    int ci, cj;
    r = '0;
    if (b.chl <= 0) begin
      r.st = ST_CHL;
    end else if (b.r443 <= 0 || b.r555 <= 0) begin
      r.st = ST_REFL;
    end else begin
      t = bracket_frac(1'b0, x_cnt, (longint'(b.r412) * 65536) / longint'(b.r443), ci);
      u = bracket_frac(1'b1, y_cnt, (longint'(b.r490) * 65536) / longint'(b.r555), cj);
      a[0] = ci*DIM + cj;
      a[1] = ci*DIM + cj + 1;
      a[2] = (ci+1)*DIM + cj + 1;
      a[3] = (ci+1)*DIM + cj;
      w[0] = (65536 - t) * (65536 - u);
      w[1] = (65536 - t) * u;
      w[2] = t * u;
      w[3] = t * (65536 - u);
      wt = 0;
      num_i = 0;
      num_c = 0;
      for (int c = 0; c < 4; c++) begin
        if (idx_tbl[a[c]] <= -65536) w[c] = 0;
        wt += w[c];
        num_i += longint'(idx_tbl[a[c]]) * w[c];
        num_c += longint'(chl_tbl[a[c]]) * w[c];
      end
      if (wt == 0) begin
        r.st = ST_MISS;
      end else begin
        r.st = ST_OK;
        r.idx = 32'(num_i / wt);
        r.chl = 32'(num_c / wt);
      end
    end
    return r;
  endfunction

  // present one beat, wait for acceptance, then update the shadow state
  task automatic send_beat(input pixel_beat_t b, input bit paced, input bit typed,
                           input lookup_res_t typed_res);
    in_valid <= 1'b1;
    in_operation <= b.op;
    in_column_select <= b.col;
    in_row_select <= b.row;
    in_load_value <= b.val;
    in_chlorophyll_in <= b.chl;
    in_refl_412 <= b.r412;
    in_refl_443 <= b.r443;
    in_refl_490 <= b.r490;
    in_refl_555 <= b.r555;
    do @(posedge clk); while (in_stall);
    case (b.op)
      OP_LOAD_X:   x_ax[b.col] = b.val;
      OP_LOAD_Y:   y_ax[b.row] = b.val;
      OP_LOAD_IDX: idx_tbl[b.col*DIM + b.row] = b.val;
      OP_LOAD_CHL: chl_tbl[b.col*DIM + b.row] = b.val;
      OP_COMP:     pending_lookups.push_back(typed ? typed_res : lookup_pixel(b));
      default: ;
    endcase
    if (paced) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 16);
      end
    end
  endtask

  // caller drops cfg_valid after the last write
  task automatic write_count(input cfg_idx_e which, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    if (which == CFG_X_CNT) x_cnt = v;
    else y_cnt = v;
  endtask

  // low entries step finely; the rest sit far above any ratio sent
  function automatic int axis_base(input bit on_y, input int k);
    if (k >= REG - 1) return 1073741824 + k*65536;
    return on_y ? 16384 + k*8192 : 32768 + k*8192;
  endfunction

  // reflectance pair giving a ratio near q (Q16)
  function automatic logic [63:0] refl_pair(input int q);
    logic signed [31:0] den;
    den = 32'($urandom_range(1 << 16, 1 << 24));
    return {32'((longint'(den) * q) >>> 16), den};
  endfunction

  function automatic pixel_beat_t random_beat();
    pixel_beat_t b;
    int sel;
    logic [63:0] p;
    b.op = OP_COMP;
    b.col = 7'($urandom_range(0, DIM-1));
    b.row = 7'($urandom_range(0, DIM-1));
    b.val = $urandom;
    b.chl = 32'($urandom_range(1, 32'h7FFF_FFFF));
    p = refl_pair($urandom_range(0, 1200000));
    {b.r412, b.r443} = p;
    p = refl_pair($urandom_range(0, 1200000));
    {b.r490, b.r555} = p;
    sel = $urandom_range(0, 99);
    if (sel < 28) begin
      b.op = ($urandom_range(0, 1) == 0) ? OP_LOAD_IDX : OP_LOAD_CHL;
      if ($urandom_range(0, 7) != 0) begin
        b.col = 7'($urandom_range(0, REG-1));
        b.row = 7'($urandom_range(0, REG-1));
      end
      if ($urandom_range(0, 3) == 0) b.val = MISSING;
      else if ($urandom_range(0, 1) == 0) b.val = 32'($urandom_range(0, 40 << 16));
    end else if (sel < 36) begin
      b.op = ($urandom_range(0, 1) == 0) ? OP_LOAD_X : OP_LOAD_Y;
      if ($urandom_range(0, 7) != 0) begin
        b.val = axis_base(b.op == OP_LOAD_Y, (b.op == OP_LOAD_Y) ? b.row : b.col)
                + $urandom_range(0, 4000) - 2000;
      end else begin
        // wild entries only inside the fine part, never the first
        b.col = 7'($urandom_range(1, REG-2));
        b.row = 7'($urandom_range(1, REG-2));
      end
    end else if (sel < 39) begin
      b.op = 3'($urandom_range(5, 7));
    end else if (sel < 45) begin
      // small numerators keep any valid ratio below the coarse axis part
      b.r412 = $signed($urandom) >>> 17;
      b.r443 = $urandom;
      b.r490 = $signed($urandom) >>> 17;
      b.r555 = $urandom;
      if ($urandom_range(0, 1) == 0) b.chl = $urandom;
    end else if (sel < 48) begin
      b.chl = -32'($urandom_range(0, 32'h7FFF_FFFF));
    end
    return b;
  endfunction

  // directed cases, run with both counts at their reset value of 2
  dir_row_t dir_rows [24] = '{
    '{'{OP_COMP, 7'd0, 7'd0, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd1, 32'sd1},
      1'b1, '{32'sd0, 32'sd0, ST_CHL}},
    '{'{OP_COMP, 7'd0, 7'd0, 32'sd0, 32'h8000_0000, 32'sd1, 32'sd0, 32'sd1, 32'sd1},
      1'b1, '{32'sd0, 32'sd0, ST_CHL}},
    '{'{OP_COMP, 7'd0, 7'd0, 32'sd0, 32'sd1, 32'sd1, 32'sd0, 32'sd1, 32'sd1},
      1'b1, '{32'sd0, 32'sd0, ST_REFL}},
    '{'{OP_COMP, 7'd0, 7'd0, 32'sd0, 32'h7FFF_FFFF, 32'sd1, 32'sd1, 32'sd1, 32'h8000_0000},
      1'b1, '{32'sd0, 32'sd0, ST_REFL}},
    '{'{OP_COMP, 7'd0, 7'd0, 32'sd0, 32'sd65536, 32'h100_0000, 32'h100_0000,
        32'h100_0000, 32'h100_0000}, 1'b0, '0},
    '{'{OP_LOAD_IDX, 7'd0, 7'd0, MISSING, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
    '{'{OP_LOAD_IDX, 7'd0, 7'd1, MISSING, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
    '{'{OP_LOAD_IDX, 7'd1, 7'd0, MISSING, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
    '{'{OP_LOAD_IDX, 7'd1, 7'd1, MISSING, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
    '{'{OP_COMP, 7'd0, 7'd0, 32'sd0, 32'sd65536, 32'sd1, 32'h7FFF_FFFF, 32'sd1,
        32'h7FFF_FFFF}, 1'b1, '{32'sd0, 32'sd0, ST_MISS}},
    '{'{OP_LOAD_IDX, 7'd1, 7'd1, 32'h7FFF_FFFF, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      1'b0, '0},
    '{'{OP_LOAD_CHL, 7'd1, 7'd1, 32'h8000_0000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      1'b0, '0},
    // ratios beyond both axes: only the far corner carries weight
    '{'{OP_COMP, 7'd0, 7'd0, 32'sd0, 32'sd65536, 32'h100_0000, 32'h100_0000,
        32'h100_0000, 32'h100_0000}, 1'b1, '{32'h7FFF_FFFF, 32'h8000_0000, ST_OK}},
    '{'{OP_LOAD_IDX, 7'd1, 7'd1, -32'sd65535, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      1'b0, '0},
    '{'{OP_COMP, 7'd0, 7'd0, 32'sd0, 32'sd65536, 32'h100_0000, 32'h100_0000,
        32'h100_0000, 32'h100_0000}, 1'b1, '{-32'sd65535, 32'h8000_0000, ST_OK}},
    // exactly -1.0 counts as missing
    '{'{OP_LOAD_IDX, 7'd1, 7'd1, -32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      1'b0, '0},
    '{'{OP_COMP, 7'd0, 7'd0, 32'sd0, 32'sd65536, 32'h100_0000, 32'h100_0000,
        32'h100_0000, 32'h100_0000}, 1'b1, '{32'sd0, 32'sd0, ST_MISS}},
    '{'{3'd5, 7'd0, 7'd0, 32'sd0, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1}, 1'b0, '0},
    '{'{3'd7, 7'd127, 7'd127, 32'sd0, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1}, 1'b0, '0},
    // flat x axis gives a zero fraction
    '{'{OP_LOAD_X, 7'd1, 7'd0, 32'sd32768, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
    '{'{OP_COMP, 7'd0, 7'd0, 32'sd0, 32'sd65536, 32'h100_0000, 32'h100_0000,
        32'h80_0000, 32'h100_0000}, 1'b0, '0},
    '{'{OP_LOAD_X, 7'd1, 7'd0, 32'sd40960, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, '0},
    '{'{OP_LOAD_IDX, 7'd127, 7'd127, 32'h8000_0000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      1'b0, '0},
    '{'{OP_LOAD_CHL, 7'd127, 7'd127, 32'h7FFF_FFFF, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      1'b0, '0}
  };

  // result side stalls in runs of a random mode
  int stall_mode = 0;
  int stall_run = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_run = $urandom_range(1, 64);
      end else begin
        stall_run--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    lookup_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_lookups.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: idx %0d chl %0d status %0d",
                                   out_index_out, out_chlorophyll_out, out_status);
      end else begin
        want = pending_lookups.pop_front();
        if (out_index_out !== want.idx || out_chlorophyll_out !== want.chl ||
            out_status !== want.st) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: idx %0d/%0d chl %0d/%0d status %0d/%0d (exp/got)",
                     want.idx, out_index_out, want.chl, out_chlorophyll_out,
                     want.st, out_status);
        end
      end
    end
  end

  // main sequence
  initial begin
    pixel_beat_t b;
    logic [7:0] x_set [6] = '{8'd128, 8'd0, 8'd17, 8'd255, 8'd64, 8'd2};
    logic [7:0] y_set [6] = '{8'd128, 8'd255, 8'd40, 8'd1, 8'd3, 8'd128};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill axes and the reachable table corner so no compute reads an
    // unwritten entry
    b = '0;
    for (int k = 0; k < DIM; k++) begin
      b.op = OP_LOAD_X; b.col = 7'(k); b.val = axis_base(1'b0, k);
      send_beat(b, 1'b0, 1'b0, '0);
      b.op = OP_LOAD_Y; b.row = 7'(k); b.val = axis_base(1'b1, k);
      send_beat(b, 1'b0, 1'b0, '0);
    end
    for (int c = 0; c < REG; c++)
      for (int r = 0; r < REG; r++) begin
        b.col = 7'(c); b.row = 7'(r);
        b.op = OP_LOAD_IDX;
        b.val = ($urandom_range(0, 4) == 0) ? MISSING : 32'($urandom_range(0, 20 << 16));
        send_beat(b, 1'b0, 1'b0, '0);
        b.op = OP_LOAD_CHL; b.val = $urandom_range(0, 50 << 16);
        send_beat(b, 1'b0, 1'b0, '0);
      end

    foreach (dir_rows[n])
      send_beat(dir_rows[n].b, 1'b1, dir_rows[n].typed, dir_rows[n].r);
    in_valid <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      wait (pending_lookups.size() == 0);
      repeat (SETTLE) @(posedge clk);
      write_count(CFG_X_CNT, x_set[ph]);
      write_count(CFG_Y_CNT, y_set[ph]);
      cfg_valid <= 1'b0;
      for (int n = 0; n < PHASE_BEATS; n++)
        send_beat(random_beat(), 1'b1, 1'b0, '0);
      in_valid <= 1'b0;
    end

    wait (pending_lookups.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending_lookups.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // watchdog
  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
